/* design/timestamp_gap_event_profiler_defines.svh */
// Assertion macros used by the timestamp gap event profiler checker.
`ifndef TIMESTAMP_GAP_EVENT_PROFILER_DEFINES_SVH
`define TIMESTAMP_GAP_EVENT_PROFILER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TGEP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TGEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tgep_pkg.sv */
// Types and constants shared by the timestamp gap event profiler.
package tgep_pkg;

  localparam int TimeBits = 64;
  localparam logic [63:0] TimeMask = {64{1'b1}} >> (64 - TimeBits);
  localparam logic [63:0] AllOnes = {64{1'b1}};

  localparam int PaddrW = 3;
  localparam logic RegGapThreshold = 1'b0;
  localparam logic RegEventLimit = 1'b1;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdRearm = 1'b1;

  localparam logic [30:0] GapThresholdReset = 31'd1000;
  localparam logic [15:0] EventLimitReset = 16'd100;

  typedef struct packed {
    logic [30:0] gap_threshold;
    logic [15:0] event_limit;
  } cfg_t;

  // Declared from the top bit down so that event_index lands in the low bits.
  typedef struct packed {
    logic [63:0] sum_inactive;
    logic [63:0] max_inactive;
    logic [63:0] min_inactive;
    logic [63:0] sum_active;
    logic [63:0] max_active;
    logic [63:0] min_active;
    logic [63:0] inactive_span;
    logic [63:0] active_span;
    logic [63:0] gap_end;
    logic [63:0] gap_start;
    logic [15:0] event_index;
  } out_data_t;

  localparam int OutDataW = $bits(out_data_t);

endpackage

/* design/tgep_cfg.sv */
// APB register file holding the gap threshold and the event limit.
module tgep_cfg import tgep_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        RegGapThreshold: cfg_d.gap_threshold = pwdata[30:0];
        RegEventLimit:   cfg_d.event_limit   = pwdata[15:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegGapThreshold: prdata = {1'b0, cfg_q.gap_threshold};
      RegEventLimit:   prdata = {16'd0, cfg_q.event_limit};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_threshold <= GapThresholdReset;
      cfg_q.event_limit   <= EventLimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/tgep_core.sv */
// Capture state, gap detection and running statistics; one word per fired cycle.
module tgep_core import tgep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic        cmd_i,
  input  logic [63:0] time_i,
  input  cfg_t        cfg_i,
  output logic        hit_o,
  output out_data_t   data_o,
  output logic        final_o
);

  logic [63:0] prev_sample_q, prev_sample_d;
  logic        primed_q, primed_d;
  logic [63:0] prev_gap_end_q, prev_gap_end_d;
  logic [15:0] event_count_q, event_count_d;
  logic        done_q, done_d;
  logic [63:0] act_min_q, act_min_d, act_max_q, act_max_d, act_sum_q, act_sum_d;
  logic [63:0] ina_min_q, ina_min_d, ina_max_q, ina_max_d, ina_sum_q, ina_sum_d;

  logic [63:0] t;
  logic [63:0] inact;
  logic [63:0] act;
  logic        gap_hit;
  logic        sample_ok;
  logic [64:0] act_sum_full, ina_sum_full;
  logic [15:0] limit;
  logic [16:0] count_inc;

  assign t         = time_i & TimeMask;
  assign inact     = t - prev_sample_q;
  assign act       = (prev_sample_q >= prev_gap_end_q) ? (prev_sample_q - prev_gap_end_q)
                                                       : 64'd0;
  assign sample_ok = (cmd_i == CmdSample) && !done_q && primed_q;
  assign gap_hit   = sample_ok && (t >= prev_sample_q)
                     && (inact >= {33'd0, cfg_i.gap_threshold});

  assign act_sum_full = {1'b0, act_sum_q} + {1'b0, act};
  assign ina_sum_full = {1'b0, ina_sum_q} + {1'b0, inact};
  assign limit        = (cfg_i.event_limit == 16'd0) ? 16'd1 : cfg_i.event_limit;
  assign count_inc    = {1'b0, event_count_q} + 17'd1;

  always_comb begin
    data_o.event_index   = event_count_q;
    data_o.gap_start     = prev_sample_q;
    data_o.gap_end       = t;
    data_o.active_span   = act;
    data_o.inactive_span = inact;
    data_o.min_active    = (act < act_min_q) ? act : act_min_q;
    data_o.max_active    = (act > act_max_q) ? act : act_max_q;
    data_o.sum_active    = act_sum_full[64] ? AllOnes : act_sum_full[63:0];
    data_o.min_inactive  = (inact < ina_min_q) ? inact : ina_min_q;
    data_o.max_inactive  = (inact > ina_max_q) ? inact : ina_max_q;
    data_o.sum_inactive  = ina_sum_full[64] ? AllOnes : ina_sum_full[63:0];
  end

  assign final_o = count_inc >= {1'b0, limit};
  assign hit_o   = gap_hit;

  always_comb begin
    prev_sample_d  = prev_sample_q;
    primed_d       = primed_q;
    prev_gap_end_d = prev_gap_end_q;
    event_count_d  = event_count_q;
    done_d         = done_q;
    act_min_d      = act_min_q;
    act_max_d      = act_max_q;
    act_sum_d      = act_sum_q;
    ina_min_d      = ina_min_q;
    ina_max_d      = ina_max_q;
    ina_sum_d      = ina_sum_q;
    if (fire_i) begin
      if (cmd_i == CmdRearm) begin
        prev_sample_d  = 64'd0;
        primed_d       = 1'b0;
        prev_gap_end_d = 64'd0;
        event_count_d  = 16'd0;
        done_d         = 1'b0;
        act_min_d      = AllOnes;
        act_max_d      = 64'd0;
        act_sum_d      = 64'd0;
        ina_min_d      = AllOnes;
        ina_max_d      = 64'd0;
        ina_sum_d      = 64'd0;
      end else if (!done_q) begin
        prev_sample_d = t;
        primed_d      = 1'b1;
        if (gap_hit) begin
          prev_gap_end_d = t;
          event_count_d  = count_inc[15:0];
          done_d         = final_o;
          act_min_d      = data_o.min_active;
          act_max_d      = data_o.max_active;
          act_sum_d      = data_o.sum_active;
          ina_min_d      = data_o.min_inactive;
          ina_max_d      = data_o.max_inactive;
          ina_sum_d      = data_o.sum_inactive;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sample_q  <= 64'd0;
      primed_q       <= 1'b0;
      prev_gap_end_q <= 64'd0;
      event_count_q  <= 16'd0;
      done_q         <= 1'b0;
      act_min_q      <= AllOnes;
      act_max_q      <= 64'd0;
      act_sum_q      <= 64'd0;
      ina_min_q      <= AllOnes;
      ina_max_q      <= 64'd0;
      ina_sum_q      <= 64'd0;
    end else begin
      prev_sample_q  <= prev_sample_d;
      primed_q       <= primed_d;
      prev_gap_end_q <= prev_gap_end_d;
      event_count_q  <= event_count_d;
      done_q         <= done_d;
      act_min_q      <= act_min_d;
      act_max_q      <= act_max_d;
      act_sum_q      <= act_sum_d;
      ina_min_q      <= ina_min_d;
      ina_max_q      <= ina_max_d;
      ina_sum_q      <= ina_sum_d;
    end
  end

endmodule

/* design/timestamp_gap_event_profiler.sv */
// Top level of the timestamp gap event profiler: stream ports, staging registers.
//
//   Channel  | Direction | Contents
//   s_axis   | in        | tuser = cmd (0 sample, 1 rearm), tdata = sample_time
//   m_axis   | out       | tdata = one event record, tlast = final_event
//   apb      | in/out    | gap_threshold at 0x0, event_limit at 0x4
//
// One word is accepted per cycle while the output side keeps up. A word is held
// in the input register, is evaluated against the capture state in the cycle
// it moves on, and its event (if any) shows up in the output register the cycle
// after. Rearm words and samples without a gap produce nothing. When the output
// stalls with a record waiting, the input register fills and then tready drops.
// Reset clears the capture state, the config registers and both valid flags.
module timestamp_gap_event_profiler import tgep_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,  // [63:0] sample_time
  input  logic                s_axis_tuser,  // [0] cmd
  // Output stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] event_index, [79:16] gap_start, [143:80] gap_end,
  // [207:144] active_span, [271:208] inactive_span, [335:272] min_active,
  // [399:336] max_active, [463:400] sum_active, [527:464] min_inactive,
  // [591:528] max_inactive, [655:592] sum_inactive
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t        cfg;
  logic        in_valid_q;
  logic        in_cmd_q;
  logic [63:0] in_time_q;
  logic        out_valid_q;
  out_data_t   out_data_q;
  logic        out_last_q;
  logic        advance;
  logic        hit;
  out_data_t   res_data;
  logic        res_final;

  tgep_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The staged word moves on whenever the output register is free or is
  // being emptied in this same cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  tgep_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .cmd_i   (in_cmd_q),
    .time_i  (in_time_q),
    .cfg_i   (cfg),
    .hit_o   (hit),
    .data_o  (res_data),
    .final_o (res_final)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= hit;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; the valid flags qualify them.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= s_axis_tuser;
      in_time_q <= s_axis_tdata;
    end
    if (advance && hit) begin
      out_data_q <= res_data;
      out_last_q <= res_final;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* design/tgep_checker.sv */
// Port-level checker for the timestamp gap event profiler and its bind.
`include "timestamp_gap_event_profiler_defines.svh"

module tgep_checker import tgep_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  out_data_t d;
  assign d = out_data_t'(m_axis_tdata);

  `TGEP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")
  `TGEP_ASSERT_NOW(a_inactive_span, m_axis_tvalid, d.inactive_span == d.gap_end - d.gap_start, "inactive span does not match gap bounds")
  `TGEP_ASSERT_NOW(a_active_bounds, m_axis_tvalid, (d.min_active <= d.active_span) && (d.active_span <= d.max_active) && (d.active_span <= d.sum_active), "active span outside its running statistics")
  `TGEP_ASSERT_NOW(a_inactive_bounds, m_axis_tvalid, (d.min_inactive <= d.inactive_span) && (d.inactive_span <= d.max_inactive) && (d.inactive_span <= d.sum_inactive), "inactive span outside its running statistics")

endmodule

bind timestamp_gap_event_profiler tgep_checker u_tgep_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
